[rtl/core/ipv6_address_to_text_macros.svh]
// Assertion macros shared by the IPv6 address text formatter.
`ifndef IPV6_ADDRESS_TO_TEXT_MACROS_SVH
`define IPV6_ADDRESS_TO_TEXT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/core/ipv6txt_pkg.sv]
// Package with constants, types and helper functions for the IPv6 address text formatter.
`timescale 1ns / 1ps
package ipv6txt_pkg;

  localparam int ADDRESS_BYTES = 16;
  localparam int GROUPS        = ADDRESS_BYTES / 2;
  localparam int GROUP_W       = $clog2(GROUPS);
  localparam int RUN_W         = GROUP_W + 1;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  // ASCII codes used in the text.
  localparam logic [6:0] CHAR_COLON = 7'h3a;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_ALPHA = 7'h57;

  // Run boundary that no group index reaches, marking "no zero run".
  localparam logic [RUN_W-1:0] NO_RUN = RUN_W'(GROUPS);

  // One classified address as it travels through the queue.
  typedef struct packed {
    logic [63:0]      addr_high;
    logic [63:0]      addr_low;
    logic [RUN_W-1:0] run_start;
    logic [RUN_W-1:0] run_end;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // Picks 16-bit group g, group 0 being the top of the high half.
  function automatic logic [15:0] group_sel(input logic [63:0] hi, input logic [63:0] lo,
                                            input logic [GROUP_W-1:0] g);
    logic [127:0]       w;
    logic [GROUP_W-1:0] r;
    w = {hi, lo};
    r = GROUP_W'(GROUPS - 1) - g;
    return w[{r, 4'b0000} +: 16];
  endfunction

  // Index of the first non-zero nibble, or the bottom nibble for a zero group.
  function automatic logic [1:0] lead_nibble(input logic [15:0] v);
    logic [1:0] r;
    if (v[15:12] != 4'h0) begin
      r = 2'd3;
    end else if (v[11:8] != 4'h0) begin
      r = 2'd2;
    end else if (v[7:4] != 4'h0) begin
      r = 2'd1;
    end else begin
      r = 2'd0;
    end
    return r;
  endfunction

  // Lowercase hexadecimal digit.
  function automatic logic [6:0] hex_char(input logic [3:0] n);
    logic [6:0] r;
    if (n < 4'd10) begin
      r = CHAR_ZERO + {3'b000, n};
    end else begin
      r = CHAR_ALPHA + {3'b000, n};
    end
    return r;
  endfunction

endpackage

[rtl/core/ipv6txt_front.sv]
// Front end: accepts an address and finds the zero run to be elided.
`timescale 1ns / 1ps
module ipv6txt_front (
  input  logic                  push,
  output logic                  full,
  input  logic [63:0]           addr_high,
  input  logic [63:0]           addr_low,
  input  ipv6txt_pkg::q_status_t q_stat,
  output logic                  q_wr,
  output ipv6txt_pkg::item_t    q_item
);
  import ipv6txt_pkg::*;

  logic [RUN_W-1:0] cur_len;
  logic [RUN_W-1:0] best_len;
  logic [RUN_W-1:0] best_start;

  // Scan the eight groups for the first longest run of zero groups.
  always_comb begin
    cur_len    = '0;
    best_len   = '0;
    best_start = NO_RUN;
    for (int i = 0; i < GROUPS; i++) begin
      if (group_sel(addr_high, addr_low, GROUP_W'(i)) == 16'h0000) begin
        cur_len = cur_len + 1'b1;
        if (cur_len > best_len) begin
          best_len   = cur_len;
          best_start = RUN_W'(i) + 1'b1 - cur_len;
        end
      end else begin
        cur_len = '0;
      end
    end
  end

  // A single zero group is never elided.
  always_comb begin
    q_item.addr_high = addr_high;
    q_item.addr_low  = addr_low;
    if (best_len < RUN_W'(2)) begin
      q_item.run_start = NO_RUN;
      q_item.run_end   = NO_RUN;
    end else begin
      q_item.run_start = best_start;
      q_item.run_end   = best_start + best_len;
    end
  end

  assign full = q_stat.full;
  assign q_wr = push && !q_stat.full;

endmodule

[rtl/core/ipv6txt_queue.sv]
// Two-entry queue of classified words between the front and back ends.
`timescale 1ns / 1ps
module ipv6txt_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr,
  input  ipv6txt_pkg::item_t     wr_item,
  input  logic                   rd,
  output ipv6txt_pkg::item_t     head,
  output ipv6txt_pkg::q_status_t stat
);
  import ipv6txt_pkg::*;

  item_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + QCNT_W'(wr) - QCNT_W'(rd);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wptr] <= wr_item;
    end
  end

  assign head       = entries[rptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == QCNT_W'(QDEPTH));

endmodule

[rtl/core/ipv6txt_back.sv]
// Back end: sequencer that prints one character of the address text per cycle unless a held output word stalls it.
`timescale 1ns / 1ps
module ipv6txt_back (
  input  logic                   clk,
  input  logic                   rst,
  input  ipv6txt_pkg::q_status_t q_stat,
  input  ipv6txt_pkg::item_t     head,
  output logic                   q_rd,
  input  logic                   pop,
  output logic                   empty,
  output logic [6:0]             text_char,
  output logic                   last_char
);
  import ipv6txt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_COLON1 = 5'b00010,
    S_COLON2 = 5'b00100,
    S_SEP    = 5'b01000,
    S_DIGIT  = 5'b10000
  } state_t;

  typedef struct packed {
    state_t     state;
    logic [1:0] k;
  } enter_t;

  state_t             state;
  state_t             state_next;
  item_t              cur;
  logic [GROUP_W-1:0] g;
  logic [GROUP_W-1:0] g_next;
  logic [1:0]         k;
  logic [1:0]         k_next;
  logic               out_valid;
  logic               pop_ok;
  logic               advance;
  logic               emit;
  logic [6:0]         emit_char;
  logic               emit_last;
  logic [15:0]        gv;
  logic [3:0]         nib;
  enter_t             e_head;
  enter_t             e_next;

  // Decides how a group opens: elided run, separator, or straight into digits.
  function automatic enter_t enter_group(input item_t it, input logic [GROUP_W-1:0] gi);
    enter_t r;
    r.k = lead_nibble(group_sel(it.addr_high, it.addr_low, gi));
    if ({1'b0, gi} == it.run_start) begin
      r.state = S_COLON1;
    end else if (gi != '0 && {1'b0, gi} != it.run_end) begin
      r.state = S_SEP;
    end else begin
      r.state = S_DIGIT;
    end
    return r;
  endfunction

  assign pop_ok  = pop && out_valid;
  assign advance = !out_valid || pop_ok;
  assign q_rd    = (state == S_IDLE) && !q_stat.empty;
  assign gv      = group_sel(cur.addr_high, cur.addr_low, g);
  assign nib     = gv[{k, 2'b00} +: 4];
  assign e_head  = enter_group(head, '0);
  assign e_next  = enter_group(cur, g + 1'b1);

  // Next state and the character produced this cycle.
  always_comb begin
    state_next = state;
    g_next     = g;
    k_next     = k;
    emit       = 1'b0;
    emit_char  = CHAR_COLON;
    emit_last  = 1'b0;
    case (state)
      S_IDLE: begin
        if (!q_stat.empty) begin
          state_next = e_head.state;
          k_next     = e_head.k;
          g_next     = '0;
        end
      end
      S_COLON1: begin
        if (advance) begin
          emit       = 1'b1;
          state_next = S_COLON2;
        end
      end
      S_COLON2: begin
        if (advance) begin
          emit      = 1'b1;
          emit_last = (cur.run_end == NO_RUN);
          if (cur.run_end == NO_RUN) begin
            state_next = S_IDLE;
          end else begin
            g_next     = cur.run_end[GROUP_W-1:0];
            k_next     = lead_nibble(group_sel(cur.addr_high, cur.addr_low,
                                               cur.run_end[GROUP_W-1:0]));
            state_next = S_DIGIT;
          end
        end
      end
      S_SEP: begin
        if (advance) begin
          emit       = 1'b1;
          k_next     = lead_nibble(gv);
          state_next = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (advance) begin
          emit      = 1'b1;
          emit_char = hex_char(nib);
          if (k == 2'd0) begin
            if (g == GROUP_W'(GROUPS - 1)) begin
              emit_last  = 1'b1;
              state_next = S_IDLE;
            end else begin
              g_next     = g + 1'b1;
              k_next     = e_next.k;
              state_next = e_next.state;
            end
          end else begin
            k_next = k - 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state and output word valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop_ok) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Held address, group and nibble position, and the output word.
  always_ff @(posedge clk) begin
    g <= g_next;
    k <= k_next;
    if (q_rd) begin
      cur <= head;
    end
    if (emit) begin
      text_char <= emit_char;
      last_char <= emit_last;
    end
  end

  assign empty = !out_valid;

endmodule

[rtl/core/ipv6_address_to_text.sv]
// Top level of the IPv6 address to canonical text formatter.
//
//   channel  direction  handshake    payload
//   address  in         push / full  addr_high[63:0], addr_low[63:0]
//   text     out        pop / empty  text_char[6:0], last_char
//
// An address is classified in the cycle it is accepted and waits in a two-word queue.
// The sequencer takes it from the queue in its idle state, then prints one character
// per cycle while the output keeps up: 2 to 39 characters per address.
// The queue keeps accepting, until it is full, while the sequencer or the output is stalled.
// A held output word stops the sequencer until it is popped.
// Synchronous reset empties the queue and the output and idles the sequencer.
`timescale 1ns / 1ps
`include "ipv6_address_to_text_macros.svh"
module ipv6_address_to_text (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [63:0] addr_high,
  input  logic [63:0] addr_low,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  text_char,
  output logic        last_char
);
  import ipv6txt_pkg::*;

  q_status_t q_stat;
  item_t     q_item;
  item_t     q_head;
  logic      q_wr;
  logic      q_rd;

  ipv6txt_front u_front (
    .push      (push),
    .full      (full),
    .addr_high (addr_high),
    .addr_low  (addr_low),
    .q_stat    (q_stat),
    .q_wr      (q_wr),
    .q_item    (q_item)
  );

  ipv6txt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_item (q_item),
    .rd      (q_rd),
    .head    (q_head),
    .stat    (q_stat)
  );

  ipv6txt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head      (q_head),
    .q_rd      (q_rd),
    .pop       (pop),
    .empty     (empty),
    .text_char (text_char),
    .last_char (last_char)
  );

  // Consistency between the front end, the queue and the sequencer.
  `ASSERT_IMPLIES(a_wr_not_full, clk, rst, q_wr, !q_stat.full, "queue written while full")
  `ASSERT_IMPLIES(a_rd_not_empty, clk, rst, q_rd, !q_stat.empty, "queue read while empty")
  `ASSERT_NEXT(a_wr_fills, clk, rst, q_wr, !q_stat.empty, "queue empty after a write")
  `ASSERT_IMPLIES(a_reset_empty, clk, rst, $past(rst), empty, "output not empty after reset")

endmodule

[test/tb_ipv6_address_to_text.sv]
// Self-checking testbench for the IPv6 address to canonical text formatter.
`timescale 1ns / 1ps
module tb_ipv6_address_to_text;
  import ipv6txt_pkg::CHAR_COLON;
  import ipv6txt_pkg::CHAR_ZERO;

  localparam logic [6:0] CHAR_LOWER_A = 7'h61;
  localparam int         GROUP_COUNT  = 8;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         TAIL_CYCLES  = 80;
  localparam int         SHOWN_ERRORS = 10;

  // One character of the expected text.
  typedef struct {
    logic [6:0] ch;
    logic       fin;
  } text_word_t;

  // One address waiting to be offered, with the handshake behaviour around it.
  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    int          send_idle;
    int          recv_idle;
    bit          drain_first;
    bit          hold_output;
  } address_job_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [63:0] addr_high = 64'h0;
  logic [63:0] addr_low = 64'h0;
  logic        full;
  logic        empty;
  logic [6:0]  text_char;
  logic        last_char;

  address_job_t pending_addresses[$];
  text_word_t   expected_text[$];

  int recv_idle = 73;
  int hold_req_id = 0;
  int addresses_sent = 0;
  int chars_checked = 0;
  int runs_elided = 0;
  int errors = 0;

  ipv6_address_to_text dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .addr_high (addr_high),
    .addr_low  (addr_low),
    .empty     (empty),
    .pop       (pop),
    .text_char (text_char),
    .last_char (last_char)
  );

  // Free-running clock with an 8 ns period.
  initial begin
    forever #4 clk = ~clk;
  end

  // Works out the canonical text of one address and appends it to the expected text.
  task automatic predict_text(input logic [63:0] hi, input logic [63:0] lo);
    logic [127:0] whole;
    logic [15:0]  grp [GROUP_COUNT];
    logic [3:0]   nib;
    int           run_len;
    int           best_len;
    int           best_at;
    int           g;
    int           k;
    bit           lead;
    text_word_t   chars[$];
    whole = {hi, lo};
    for (g = 0; g < GROUP_COUNT; g++) begin
      grp[g] = whole[127 - 16 * g -: 16];
    end
    // Longest run of zero groups; a strictly longer run replaces the earlier one.
    run_len = 0;
    best_len = 0;
    best_at = GROUP_COUNT;
    for (g = 0; g < GROUP_COUNT; g++) begin
      if (grp[g] == 16'h0) begin
        run_len++;
        if (run_len > best_len) begin
          best_len = run_len;
          best_at = g + 1 - run_len;
        end
      end else begin
        run_len = 0;
      end
    end
    // A lone zero group is printed, never elided.
    if (best_len < 2) begin
      best_len = 0;
      best_at = GROUP_COUNT;
    end else begin
      runs_elided++;
    end
    g = 0;
    while (g < GROUP_COUNT) begin
      if (g == best_at) begin
        chars.push_back('{CHAR_COLON, 1'b0});
        chars.push_back('{CHAR_COLON, 1'b0});
        g += best_len;
      end else begin
        if (g != 0 && g != best_at + best_len) begin
          chars.push_back('{CHAR_COLON, 1'b0});
        end
        // Leading zeros are dropped but the bottom digit always stays.
        lead = 1'b0;
        for (k = 3; k >= 0; k--) begin
          nib = grp[g][4 * k +: 4];
          if (nib != 4'h0 || lead || k == 0) begin
            lead = 1'b1;
            if (nib < 4'd10) begin
              chars.push_back('{CHAR_ZERO + 7'(nib), 1'b0});
            end else begin
              chars.push_back('{CHAR_LOWER_A + 7'(nib) - 7'd10, 1'b0});
            end
          end
        end
        g++;
      end
    end
    chars[chars.size() - 1].fin = 1'b1;
    foreach (chars[i]) begin
      expected_text.push_back(chars[i]);
    end
  endtask

  task automatic add_job(input logic [127:0] a, input int send_idle, input int recv_pct,
                         input bit drain_first, input bit hold_output);
    address_job_t job;
    job.hi = a[127:64];
    job.lo = a[63:0];
    job.send_idle = send_idle;
    job.recv_idle = recv_pct;
    job.drain_first = drain_first;
    job.hold_output = hold_output;
    pending_addresses.push_back(job);
  endtask

  // Group with a random number of significant digits, zero being the most likely.
  function automatic logic [15:0] random_group();
    logic [15:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = 16'h0;
      4:          v = 16'($urandom_range(15, 1));
      5:          v = 16'($urandom_range(255, 16));
      6:          v = 16'($urandom_range(4095, 256));
      default:    v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [127:0] random_address();
    logic [127:0] a;
    int           g;
    if ($urandom_range(4) == 0) begin
      a = {$urandom, $urandom, $urandom, $urandom};
    end else begin
      for (g = 0; g < GROUP_COUNT; g++) begin
        a[127 - 16 * g -: 16] = random_group();
      end
    end
    return a;
  endfunction

  // Sender: offers the next pending address and records each accepted word.
  always @(posedge clk) begin : address_driver
    address_job_t job;
    logic         offer_next;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_text(addr_high, addr_low);
        addresses_sent++;
      end
      if (!push || !full) begin
        offer_next = 1'b0;
        if (pending_addresses.size() != 0
            && !(pending_addresses[0].drain_first && expected_text.size() != 0)
            && $urandom_range(99) >= pending_addresses[0].send_idle) begin
          job = pending_addresses.pop_front();
          addr_high <= job.hi;
          addr_low <= job.lo;
          recv_idle <= job.recv_idle;
          if (job.hold_output) begin
            hold_req_id <= hold_req_id + 1;
          end
          offer_next = 1'b1;
        end
        push <= offer_next;
      end
    end
  end

  // Receiver: checks each popped word against the oldest expected character.
  always @(posedge clk) begin : text_monitor
    text_word_t want;
    int         hold_seen_id;
    int         hold_left;
    if (rst) begin
      pop <= 1'b0;
      hold_seen_id = 0;
      hold_left = 0;
    end else begin
      if (pop && !empty) begin
        chars_checked++;
        if (expected_text.size() == 0) begin
          errors++;
          if (errors <= SHOWN_ERRORS) begin
            $display("unexpected word: char %h last %b", text_char, last_char);
          end
        end else begin
          want = expected_text.pop_front();
          if (text_char !== want.ch || last_char !== want.fin) begin
            errors++;
            if (errors <= SHOWN_ERRORS) begin
              $display("word %0d: expected char %h last %b, got char %h last %b",
                       chars_checked, want.ch, want.fin, text_char, last_char);
            end
          end
        end
      end
      // A long hold-off lets the queue fill up and push back on the sender.
      if (hold_req_id != hold_seen_id) begin
        hold_seen_id = hold_req_id;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int n;
    // Edges, elision choices and digit suppression.
    add_job(128'h0000_0000_0000_0000_0000_0000_0000_0000, 17, 73, 1'b0, 1'b0);
    add_job(128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff, 17, 73, 1'b0, 1'b0);
    add_job(128'h2001_0db8_0000_0000_0000_0000_0000_0001, 17, 73, 1'b0, 1'b0);
    add_job(128'h0000_0000_0000_0000_0000_0000_0000_0001, 17, 73, 1'b0, 1'b0);
    add_job(128'h0001_0000_0000_0000_0000_0000_0000_0000, 17, 73, 1'b0, 1'b0);
    add_job(128'h0001_0000_0001_0001_0001_0001_0001_0001, 17, 73, 1'b0, 1'b0);
    add_job(128'h0000_0001_0001_0001_0001_0001_0001_0000, 17, 73, 1'b0, 1'b0);
    add_job(128'h0001_0000_0000_0001_0000_0000_0001_0001, 17, 73, 1'b0, 1'b0);
    add_job(128'h0001_0000_0000_0001_0000_0000_0000_0001, 17, 73, 1'b0, 1'b0);
    add_job(128'h0000_0000_abcd_ef01_2345_6789_0000_0001, 17, 73, 1'b0, 1'b0);
    add_job(128'h0001_0002_0003_0004_0005_0006_0000_0000, 17, 73, 1'b0, 1'b0);
    add_job(128'h0000_0001_0000_0001_0000_0001_0000_0001, 17, 73, 1'b0, 1'b0);
    add_job(128'h0001_0010_0100_1000_000f_00f0_0f00_f000, 17, 73, 1'b0, 1'b0);
    add_job(128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210, 17, 73, 1'b0, 1'b0);
    add_job(128'h0000_0000_0000_ffff_0000_0000_0000_0000, 17, 73, 1'b0, 1'b0);
    add_job(128'h0000_0000_0000_0000_ffff_0000_0000_0000, 17, 73, 1'b0, 1'b0);
    add_job(128'hffff_0000_0000_0000_0000_0000_0000_ffff, 17, 73, 1'b0, 1'b0);
    add_job(128'h8000_0000_0000_0000_0000_0000_0000_0001, 17, 73, 1'b0, 1'b0);
    add_job(128'h0000_0000_0000_0000_0000_0000_0001_0000, 17, 73, 1'b0, 1'b0);
    add_job(128'h0000_ffff_0000_ffff_0000_ffff_0000_ffff, 17, 73, 1'b0, 1'b0);
    // Random addresses: slow receiver, then slow sender, then full speed.
    for (n = 0; n < 110; n++) begin
      add_job(random_address(), 17, 73, 1'b0, 1'b0);
    end
    for (n = 0; n < 110; n++) begin
      add_job(random_address(), 73, 17, n == 0, 1'b0);
    end
    for (n = 0; n < 130; n++) begin
      add_job(random_address(), 0, 0, n == 70, n == 0);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (pending_addresses.size() != 0 || push) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d characters from %0d addresses, %0d of them with an elided run.",
             chars_checked, addresses_sent, runs_elided);
    $display("Covered three idle mixes, a long output hold-off and a full drain pause.");
    if (errors == 0) begin
      $display("ipv6_address_to_text: match");
    end else begin
      $display("%0d word(s) failed the check.", errors);
      $display("ipv6_address_to_text: mismatch");
    end
    $finish;
  end

  // Watchdog against a stalled handshake.
  initial begin
    #5_000_000;
    $display("Run timed out.");
    $display("ipv6_address_to_text: mismatch");
    $finish;
  end

endmodule
